@@ hdl/isu_pkg.sv @@
// package: types, opcodes and sizing constants for the integer set store
`timescale 1ns / 1ps

package isu_pkg;

    // store geometry
    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ELEM_W  = 32;
    localparam int CNT_W   = 10;
    localparam int MAX_W   = 31;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    // one input transfer
    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [ELEM_W-1:0] element;
    } item_t;

    // one result transfer
    typedef struct packed {
        logic             was_member;
        logic             rejected_full;
        logic [CNT_W-1:0] entry_count;
        logic             is_empty;
        logic [MAX_W-1:0] max_value;
    } result_t;

endpackage

@@ hdl/isu_ram.sv @@
// generic single-clock ram: one write port, one read port, registered read
`timescale 1ns / 1ps

module isu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/integer_set_store_unit.sv @@
// top level: set of distinct signed integers in an unsorted ram with a count
//
//  channel  | direction | payload  | handshake
//  ---------+-----------+----------+---------------------------
//  item     | in        | item_t   | item_valid / item_stall
//  result   | out       | result_t | result_valid / result_stall
//
// each item is accepted, then the stored entries are scanned through the single
// ram read port, then the result is committed.
// reset clears the count and control state; ram contents are not cleared,
// since only entries below the count are ever read.
// a stalled result holds in the output register; the commit waits for it.
`timescale 1ns / 1ps

module integer_set_store_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  isu_pkg::item_t item,
    output logic           result_valid,
    input  logic           result_stall,
    output isu_pkg::result_t result
);

    import isu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [ELEM_W-1:0]   elem_reg, elem_next;
    logic [ADDR_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic                found_reg, found_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [MAX_W-1:0]    max_reg, max_next;
    logic [ELEM_W-1:0]   last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                rd_en;
    logic [ELEM_W-1:0]   rd_data;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ELEM_W-1:0]   wr_data;

    logic                issue;
    logic                add_store;
    logic                add_refused;
    logic                remove_hit;
    logic                incl_elem;
    logic [MAX_W-1:0]    elem_floor;
    logic [MAX_W-1:0]    max_final;
    logic                out_free;

    // element store
    isu_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // commit decisions
    always_comb
    begin
        add_store   = (op_reg == OP_ADD) && !found_reg
                      && (count_reg < ADDR_W'(DEPTH - 1));
        add_refused = (op_reg == OP_ADD) && !found_reg && !add_store;
        remove_hit  = (op_reg == OP_REMOVE) && found_reg;
        elem_floor  = elem_reg[ELEM_W-1] ? '0 : elem_reg[MAX_W-1:0];
        incl_elem   = (found_reg && (op_reg != OP_REMOVE)) || add_store;
        max_final   = (incl_elem && (elem_floor > max_reg)) ? elem_floor : max_reg;
        out_free    = !out_valid_reg || !result_stall;
        issue       = idx_reg < count_reg;
    end

    // sequencer: accept, scan, commit
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        elem_next      = elem_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        found_next     = found_reg;
        pos_next       = pos_reg;
        max_next       = max_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = count_reg;
        wr_data        = elem_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next    = item.opcode;
                    elem_next  = item.element;
                    idx_next   = '0;
                    found_next = 1'b0;
                    max_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue one read per cycle
                if (issue)
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                // fold in the entry read last cycle
                if (pend_reg)
                begin
                    last_next = rd_data;
                    if (rd_data == elem_reg)
                    begin
                        found_next = 1'b1;
                        pos_next   = idx_reg - 1'b1;
                    end
                    else if (!rd_data[ELEM_W-1] && (rd_data[MAX_W-1:0] > max_reg))
                    begin
                        max_next = rd_data[MAX_W-1:0];
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    if (add_store)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg;
                        wr_data    = elem_reg;
                        count_next = count_reg + 1'b1;
                    end
                    else if (remove_hit)
                    begin
                        // last entry moves into the vacated slot
                        wr_en      = 1'b1;
                        wr_addr    = pos_reg;
                        wr_data    = last_reg;
                        count_next = count_reg - 1'b1;
                    end
                    out_valid_next         = 1'b1;
                    out_next.was_member    = found_reg;
                    out_next.rejected_full = add_refused;
                    out_next.entry_count   = CNT_W'(count_next);
                    out_next.is_empty      = (count_next == '0);
                    out_next.max_value     = max_final;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        elem_reg  <= elem_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        max_reg   <= max_next;
        last_reg  <= last_next;
        out_reg   <= out_next;
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ hdl/isu_checker.sv @@
// checker: port-level properties of the integer set store, bound to the top level
`timescale 1ns / 1ps

module isu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input isu_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input isu_pkg::result_t result
);

    import isu_pkg::*;

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second item taken during scan");

    // refusal only for an absent element
    a_reject_absent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.rejected_full && result.was_member))
        else $error("refusal reported for a member");

    // empty set has zero count and zero maximum
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_empty |->
            (result.entry_count == '0) && (result.max_value == '0))
        else $error("empty set with nonzero count or maximum");

endmodule

bind integer_set_store_unit isu_checker u_isu_checker (.*);
